### sv/frr_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// frr_pkg: shared types and constants of the fraction reducer
// Holds the per-job control record that travels from the front end through
// the job queue to the reduction engine.
// ----------------------------------------------------------------------------
package frr_pkg;

    typedef struct packed {
        logic neg;
        logic zero_den;
    } t_job_ctl;

    localparam int QUEUE_DEPTH = 2;

endpackage
`default_nettype wire

### sv/frr_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// frr_front: input classification
// Splits numerator and denominator into sign and magnitude, saturating the
// most negative value, and flags a zero denominator and the result sign.
// ----------------------------------------------------------------------------
module frr_front
    import frr_pkg::*;
#(
    parameter int DATA_WIDTH = 32
) (
    input  wire logic [DATA_WIDTH-1:0] i_numer_in,
    input  wire logic [DATA_WIDTH-1:0] i_denom_in,
    output t_job_ctl                   o_ctl,
    output logic      [DATA_WIDTH-2:0] o_numer_mag,
    output logic      [DATA_WIDTH-2:0] o_denom_mag
);

    localparam int MAG_W = DATA_WIDTH - 1;

    logic [MAG_W-1:0] numer_neg;
    logic [MAG_W-1:0] denom_neg;
    logic             numer_is_min;
    logic             denom_is_min;
    logic             numer_sign;
    logic             denom_sign;

    assign numer_sign   = i_numer_in[DATA_WIDTH-1];
    assign denom_sign   = i_denom_in[DATA_WIDTH-1];
    assign numer_neg    = ~i_numer_in[MAG_W-1:0] + MAG_W'(1);
    assign denom_neg    = ~i_denom_in[MAG_W-1:0] + MAG_W'(1);
    assign numer_is_min = numer_sign && (i_numer_in[MAG_W-1:0] == '0);
    assign denom_is_min = denom_sign && (i_denom_in[MAG_W-1:0] == '0);

    always_comb begin
        if (!numer_sign) begin
            o_numer_mag = i_numer_in[MAG_W-1:0];
        end else if (numer_is_min) begin
            o_numer_mag = '1;
        end else begin
            o_numer_mag = numer_neg;
        end

        if (!denom_sign) begin
            o_denom_mag = i_denom_in[MAG_W-1:0];
        end else if (denom_is_min) begin
            o_denom_mag = '1;
        end else begin
            o_denom_mag = denom_neg;
        end
    end

    assign o_ctl.zero_den = (i_denom_in == '0);
    assign o_ctl.neg      = (numer_sign != denom_sign) && (i_numer_in != '0);

endmodule
`default_nettype wire

### sv/frr_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// frr_queue: job queue
// A short first-in first-out buffer of classified jobs between the front end
// and the reduction engine.
// ----------------------------------------------------------------------------
module frr_queue
    import frr_pkg::*;
#(
    parameter int MAG_W = 31
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push,
    input  wire t_job_ctl         i_ctl,
    input  wire logic [MAG_W-1:0] i_numer_mag,
    input  wire logic [MAG_W-1:0] i_denom_mag,
    output logic                  o_full,
    output logic                  o_valid,
    input  wire logic             i_pop,
    output t_job_ctl              o_ctl,
    output logic      [MAG_W-1:0] o_numer_mag,
    output logic      [MAG_W-1:0] o_denom_mag
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    t_job_ctl         r_ctl   [QUEUE_DEPTH];
    logic [MAG_W-1:0] r_numer [QUEUE_DEPTH];
    logic [MAG_W-1:0] r_denom [QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic [PTR_W-1:0] n_wr_ptr;
    logic [PTR_W-1:0] n_rd_ptr;
    logic [CNT_W-1:0] n_count;
    logic             do_push;
    logic             do_pop;

    assign o_full      = (r_count == CNT_W'(QUEUE_DEPTH));
    assign o_valid     = (r_count != '0);
    assign do_push     = i_push && !o_full;
    assign do_pop      = i_pop && o_valid;
    assign o_ctl       = r_ctl[r_rd_ptr];
    assign o_numer_mag = r_numer[r_rd_ptr];
    assign o_denom_mag = r_denom[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (do_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + PTR_W'(1);
        end
        if (do_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + PTR_W'(1);
        end
        if (do_push && !do_pop) begin
            n_count = r_count + CNT_W'(1);
        end else if (do_pop && !do_push) begin
            n_count = r_count - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_ctl[r_wr_ptr]   <= i_ctl;
            r_numer[r_wr_ptr] <= i_numer_mag;
            r_denom[r_wr_ptr] <= i_denom_mag;
        end
    end

`ifndef NO_ASSERTIONS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(QUEUE_DEPTH))
        else $error("job queue count exceeds its depth");
`endif

endmodule
`default_nettype wire

### sv/frr_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// frr_back: reduction engine
// Finds the common divisor with an iterative binary algorithm, then runs a
// shared restoring divider three times: numerator by divisor, denominator by
// divisor, and reduced numerator by reduced denominator. The result sits in
// an output register until the transaction completes (a zero denominator skips both steps).
// ----------------------------------------------------------------------------
module frr_back
    import frr_pkg::*;
#(
    parameter int DATA_WIDTH = 32
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_job_valid,
    output logic                       o_job_pop,
    input  wire t_job_ctl              i_job_ctl,
    input  wire logic [DATA_WIDTH-2:0] i_numer_mag,
    input  wire logic [DATA_WIDTH-2:0] i_denom_mag,
    output logic                       o_valid,
    input  wire logic                  i_ready,
    output logic      [DATA_WIDTH-1:0] o_reduced_numer,
    output logic      [DATA_WIDTH-2:0] o_reduced_denom,
    output logic      [DATA_WIDTH-1:0] o_whole_part,
    output logic      [DATA_WIDTH-1:0] o_remainder_numer,
    output logic                       o_status
);

    localparam int MAG_W = DATA_WIDTH - 1;
    localparam int CNT_W = $clog2(MAG_W);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_GCD  = 2'd1;
    localparam logic [1:0] S_DIV  = 2'd2;
    localparam logic [1:0] S_DONE = 2'd3;

    localparam logic [1:0] PH_NUM   = 2'd0;
    localparam logic [1:0] PH_DEN   = 2'd1;
    localparam logic [1:0] PH_WHOLE = 2'd2;

    function automatic logic [DATA_WIDTH-1:0] to_signed(input logic neg,
                                                        input logic [MAG_W-1:0] mag);
        logic [DATA_WIDTH-1:0] ext;
        ext = {1'b0, mag};
        return neg ? (DATA_WIDTH'(0) - ext) : ext;
    endfunction

    logic [1:0]       r_state, n_state;
    logic [1:0]       r_phase, n_phase;
    logic             r_neg, n_neg;
    logic             r_err, n_err;
    logic [MAG_W-1:0] r_mn, n_mn;
    logic [MAG_W-1:0] r_md, n_md;
    logic [MAG_W-1:0] r_ga, n_ga;
    logic [MAG_W-1:0] r_gb, n_gb;
    logic [CNT_W-1:0] r_k, n_k;
    logic [MAG_W-1:0] r_g, n_g;
    logic [MAG_W-1:0] r_n, n_n;
    logic [MAG_W-1:0] r_quo, n_quo;
    logic [MAG_W-1:0] r_rem, n_rem;
    logic [MAG_W-1:0] r_dvs, n_dvs;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic             r_out_valid, n_out_valid;
    logic             out_load;

    logic [MAG_W:0]   sub_ab;
    logic [MAG_W-1:0] sub_ba;
    logic [MAG_W-1:0] gcd_val;
    logic [MAG_W:0]   trial;
    logic [MAG_W:0]   trial_diff;
    logic             trial_ge;
    logic [MAG_W-1:0] step_rem;
    logic [MAG_W-1:0] step_quo;
    logic             div_last;

    assign sub_ab     = {1'b0, r_ga} - {1'b0, r_gb};
    assign sub_ba     = r_gb - r_ga;
    assign gcd_val    = r_ga << r_k;
    assign trial      = {r_rem, r_quo[MAG_W-1]};
    assign trial_diff = trial - {1'b0, r_dvs};
    assign trial_ge   = !trial_diff[MAG_W];
    assign step_rem   = trial_ge ? trial_diff[MAG_W-1:0] : trial[MAG_W-1:0];
    assign step_quo   = {r_quo[MAG_W-2:0], trial_ge};
    assign div_last   = (r_cnt == CNT_W'(MAG_W - 1));

    always_comb begin
        n_state   = r_state;
        n_phase   = r_phase;
        n_neg     = r_neg;
        n_err     = r_err;
        n_mn      = r_mn;
        n_md      = r_md;
        n_ga      = r_ga;
        n_gb      = r_gb;
        n_k       = r_k;
        n_g       = r_g;
        n_n       = r_n;
        n_quo     = r_quo;
        n_rem     = r_rem;
        n_dvs     = r_dvs;
        n_cnt     = r_cnt;
        o_job_pop = 1'b0;
        out_load  = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                if (i_job_valid) begin
                    o_job_pop = 1'b1;
                    n_neg     = i_job_ctl.neg;
                    n_err     = i_job_ctl.zero_den;
                    n_mn      = i_numer_mag;
                    n_md      = i_denom_mag;
                    n_k       = '0;
                    if (i_numer_mag == '0) begin
                        n_ga = MAG_W'(1);
                        n_gb = MAG_W'(1);
                    end else begin
                        n_ga = i_numer_mag;
                        n_gb = i_denom_mag;
                    end
                    n_state = i_job_ctl.zero_den ? S_DONE : S_GCD;
                end
            end
            S_GCD: begin
                if (r_ga == r_gb) begin
                    n_g     = gcd_val;
                    n_dvs   = gcd_val;
                    n_quo   = r_mn;
                    n_rem   = '0;
                    n_cnt   = '0;
                    n_phase = PH_NUM;
                    n_state = S_DIV;
                end else if (!r_ga[0] && !r_gb[0]) begin
                    n_ga = r_ga >> 1;
                    n_gb = r_gb >> 1;
                    n_k  = r_k + CNT_W'(1);
                end else if (!r_ga[0]) begin
                    n_ga = r_ga >> 1;
                end else if (!r_gb[0]) begin
                    n_gb = r_gb >> 1;
                end else if (!sub_ab[MAG_W]) begin
                    n_ga = sub_ab[MAG_W-1:0];
                end else begin
                    n_gb = sub_ba;
                end
            end
            S_DIV: begin
                n_quo = step_quo;
                n_rem = step_rem;
                n_cnt = r_cnt + CNT_W'(1);
                if (div_last) begin
                    n_cnt = '0;
                    unique case (r_phase)
                        PH_NUM: begin
                            n_n     = step_quo;
                            n_quo   = r_md;
                            n_rem   = '0;
                            n_dvs   = r_g;
                            n_phase = PH_DEN;
                        end
                        PH_DEN: begin
                            n_quo   = r_n;
                            n_rem   = '0;
                            n_dvs   = step_quo;
                            n_phase = PH_WHOLE;
                        end
                        PH_WHOLE: begin
                            n_state = S_DONE;
                        end
                        default: begin
                            n_state = S_IDLE;
                        end
                    endcase
                end
            end
            S_DONE: begin
                if (!r_out_valid || i_ready) begin
                    out_load = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        if (out_load) begin
            n_out_valid = 1'b1;
        end else if (i_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_phase     <= PH_NUM;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_phase     <= n_phase;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_neg <= n_neg;
        r_err <= n_err;
        r_mn  <= n_mn;
        r_md  <= n_md;
        r_ga  <= n_ga;
        r_gb  <= n_gb;
        r_k   <= n_k;
        r_g   <= n_g;
        r_n   <= n_n;
        r_quo <= n_quo;
        r_rem <= n_rem;
        r_dvs <= n_dvs;
        if (out_load) begin
            if (r_err) begin
                o_reduced_numer   <= '0;
                o_reduced_denom   <= '0;
                o_whole_part      <= '0;
                o_remainder_numer <= '0;
                o_status          <= 1'b1;
            end else begin
                o_reduced_numer   <= to_signed(r_neg, r_n);
                o_reduced_denom   <= r_dvs;
                o_whole_part      <= to_signed(r_neg, r_quo);
                o_remainder_numer <= to_signed(r_neg, r_rem);
                o_status          <= 1'b0;
            end
        end
    end

    assign o_valid = r_out_valid;

`ifndef NO_ASSERTIONS
    a_gcd_operands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_GCD |-> (r_ga != '0) && (r_gb != '0))
        else $error("divisor search operand reached zero");

    a_div_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_DIV |-> r_dvs != '0)
        else $error("divider started with a zero divisor");

    a_rem_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_DIV |-> r_rem < r_dvs)
        else $error("partial remainder not below divisor");

    a_hold_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE) && r_out_valid && !i_ready |=> r_state == S_DONE)
        else $error("finished result dropped while output was stalled");
`endif

endmodule
`default_nettype wire

### sv/fraction_reducer.sv
`default_nettype none
// ----------------------------------------------------------------------------
// fraction_reducer: signed fraction reduction to lowest terms
// Normalizes the denominator sign, divides both terms by their greatest
// common divisor and splits the result into whole part and remainder.
// ----------------------------------------------------------------------------
// One result per transaction. An item is loaded from the queue, then goes
// through a binary divisor search of one subtract or shift per cycle, three
// passes through the single shared restoring divider, and the output
// register. A zero denominator skips the search and divider and returns
// status 1 with zero fields. The engine handles one item at a time; a
// two-entry queue in front of it keeps accepting items, until it is full,
// while the engine works or while a result waits to be taken.
// ----------------------------------------------------------------------------
module fraction_reducer
    import frr_pkg::*;
#(
    parameter int DATA_WIDTH = 32
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_valid,
    output logic                       o_ready,
    input  wire logic [DATA_WIDTH-1:0] i_numer_in,
    input  wire logic [DATA_WIDTH-1:0] i_denom_in,
    output logic                       o_valid,
    input  wire logic                  i_ready,
    output logic      [DATA_WIDTH-1:0] o_reduced_numer,
    output logic      [DATA_WIDTH-2:0] o_reduced_denom,
    output logic      [DATA_WIDTH-1:0] o_whole_part,
    output logic      [DATA_WIDTH-1:0] o_remainder_numer,
    output logic                       o_status
);

    localparam int MAG_W = DATA_WIDTH - 1;

    t_job_ctl         front_ctl;
    logic [MAG_W-1:0] front_numer;
    logic [MAG_W-1:0] front_denom;
    logic             queue_full;
    logic             queue_valid;
    logic             queue_pop;
    t_job_ctl         queue_ctl;
    logic [MAG_W-1:0] queue_numer;
    logic [MAG_W-1:0] queue_denom;

    assign o_ready = !queue_full;

    frr_front #(
        .DATA_WIDTH(DATA_WIDTH)
    ) u_front (
        .i_numer_in (i_numer_in),
        .i_denom_in (i_denom_in),
        .o_ctl      (front_ctl),
        .o_numer_mag(front_numer),
        .o_denom_mag(front_denom)
    );

    frr_queue #(
        .MAG_W(MAG_W)
    ) u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (i_valid),
        .i_ctl      (front_ctl),
        .i_numer_mag(front_numer),
        .i_denom_mag(front_denom),
        .o_full     (queue_full),
        .o_valid    (queue_valid),
        .i_pop      (queue_pop),
        .o_ctl      (queue_ctl),
        .o_numer_mag(queue_numer),
        .o_denom_mag(queue_denom)
    );

    frr_back #(
        .DATA_WIDTH(DATA_WIDTH)
    ) u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_job_valid      (queue_valid),
        .o_job_pop        (queue_pop),
        .i_job_ctl        (queue_ctl),
        .i_numer_mag      (queue_numer),
        .i_denom_mag      (queue_denom),
        .o_valid          (o_valid),
        .i_ready          (i_ready),
        .o_reduced_numer  (o_reduced_numer),
        .o_reduced_denom  (o_reduced_denom),
        .o_whole_part     (o_whole_part),
        .o_remainder_numer(o_remainder_numer),
        .o_status         (o_status)
    );

endmodule
`default_nettype wire

### bench/fraction_reducer_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// fraction_reducer_tb: self-checking bench for the fraction reducer
// Sends directed corner fractions and then random ones built to hit large
// common divisors, exact quotients and zero terms. Each accepted transaction
// is reduced by a scoreboard of its own and the results are compared in
// order, with random gaps and stalls on both channels.
// ----------------------------------------------------------------------------
module fraction_reducer_tb;

    localparam int W            = 32;
    localparam int LIMIT_CYCLES = 1_000_000;
    localparam int RANDOM_ITEMS = 800;
    localparam int DRAIN_CYCLES = 300;

    localparam logic [W-1:0] MAX_POS  = {1'b0, {(W-1){1'b1}}};
    localparam logic [W-1:0] MAX_NEG  = {1'b1, {(W-2){1'b0}}, 1'b1};
    localparam logic [W-1:0] MOST_NEG = {1'b1, {(W-1){1'b0}}};

    typedef struct packed {
        logic [W-1:0] reduced_numer;
        logic [W-2:0] reduced_denom;
        logic [W-1:0] whole_part;
        logic [W-1:0] remainder_numer;
        logic         status;
    } t_frac_result;

    class fraction_scoreboard;
        t_frac_result pending_fractions[$];
        int           mismatch_count = 0;

        function t_frac_result reduce_fraction(logic [W-1:0] num, logic [W-1:0] den);
            t_frac_result res;
            logic         num_neg, den_neg, neg;
            logic [W-1:0] num_mag, den_mag, a, b, t, n, d, q, r;
            res = '0;
            num_neg = num[W-1];
            den_neg = den[W-1];
            num_mag = num_neg ? ((num == MOST_NEG) ? MAX_POS : -num) : num;
            den_mag = den_neg ? ((den == MOST_NEG) ? MAX_POS : -den) : den;
            if (den_mag == 0) begin
                res.status = 1'b1;
                return res;
            end
            neg = (num_neg != den_neg) && (num_mag != 0);
            if (num_mag == 0) begin
                a = 1;
            end else begin
                a = num_mag;
                b = den_mag;
                while (b != 0) begin
                    t = a % b;
                    a = b;
                    b = t;
                end
            end
            n = num_mag / a;
            d = den_mag / a;
            q = n / d;
            r = n % d;
            res.reduced_numer   = neg ? -n : n;
            res.reduced_denom   = d[W-2:0];
            res.whole_part      = (neg && q != 0) ? -q : q;
            res.remainder_numer = (neg && r != 0) ? -r : r;
            return res;
        endfunction

        function void note_input(logic [W-1:0] num, logic [W-1:0] den);
            pending_fractions.push_back(reduce_fraction(num, den));
        endfunction

        function void check_result(t_frac_result got);
            t_frac_result exp;
            if (pending_fractions.size() == 0) begin
                $error("result with no pending fraction: numer %0d denom %0d",
                       $signed(got.reduced_numer), got.reduced_denom);
                mismatch_count++;
                return;
            end
            exp = pending_fractions.pop_front();
            if (got.reduced_numer !== exp.reduced_numer) begin
                $error("reduced_numer: expected %0d, got %0d",
                       $signed(exp.reduced_numer), $signed(got.reduced_numer));
                mismatch_count++;
            end
            if (got.reduced_denom !== exp.reduced_denom) begin
                $error("reduced_denom: expected %0d, got %0d",
                       exp.reduced_denom, got.reduced_denom);
                mismatch_count++;
            end
            if (got.whole_part !== exp.whole_part) begin
                $error("whole_part: expected %0d, got %0d",
                       $signed(exp.whole_part), $signed(got.whole_part));
                mismatch_count++;
            end
            if (got.remainder_numer !== exp.remainder_numer) begin
                $error("remainder_numer: expected %0d, got %0d",
                       $signed(exp.remainder_numer), $signed(got.remainder_numer));
                mismatch_count++;
            end
            if (got.status !== exp.status) begin
                $error("status: expected %0d, got %0d", exp.status, got.status);
                mismatch_count++;
            end
        endfunction
    endclass

    logic         i_clk;
    logic         i_rst_n;
    logic         i_valid;
    logic         o_ready;
    logic [W-1:0] i_numer_in;
    logic [W-1:0] i_denom_in;
    logic         o_valid;
    logic         i_ready;
    logic [W-1:0] o_reduced_numer;
    logic [W-2:0] o_reduced_denom;
    logic [W-1:0] o_whole_part;
    logic [W-1:0] o_remainder_numer;
    logic         o_status;

    fraction_scoreboard board = new();
    int               cycle_count = 0;
    logic             steady_in   = 1'b0;
    logic             steady_out  = 1'b0;

    fraction_reducer #(
        .DATA_WIDTH(W)
    ) dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_ready          (o_ready),
        .i_numer_in       (i_numer_in),
        .i_denom_in       (i_denom_in),
        .o_valid          (o_valid),
        .i_ready          (i_ready),
        .o_reduced_numer  (o_reduced_numer),
        .o_reduced_denom  (o_reduced_denom),
        .o_whole_part     (o_whole_part),
        .o_remainder_numer(o_remainder_numer),
        .o_status         (o_status)
    );

    initial begin
        i_clk = 1'b0;
    end

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > LIMIT_CYCLES) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    task automatic send_fraction(input logic [W-1:0] num, input logic [W-1:0] den);
        int gap;
        gap = steady_in ? 0 : $urandom_range(0, 12);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_valid    <= 1'b1;
        i_numer_in <= num;
        i_denom_in <= den;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        board.note_input(num, den);
        @(negedge i_clk);
    endtask

    task automatic take_result();
        int           stall;
        t_frac_result got;
        if ($urandom_range(0, 49) == 0) steady_out = !steady_out;
        stall = steady_out ? 0 : $urandom_range(0, 12);
        if (stall > 0) begin
            i_ready <= 1'b0;
            if ($urandom_range(0, 1)) begin
                @(posedge i_clk);
                while (!o_valid) @(posedge i_clk);
                @(negedge i_clk);
            end
            repeat (stall) @(negedge i_clk);
        end
        i_ready <= 1'b1;
        @(posedge i_clk);
        while (!o_valid) @(posedge i_clk);
        got.reduced_numer   = o_reduced_numer;
        got.reduced_denom   = o_reduced_denom;
        got.whole_part      = o_whole_part;
        got.remainder_numer = o_remainder_numer;
        got.status          = o_status;
        board.check_result(got);
        @(negedge i_clk);
    endtask

    function automatic logic [W-1:0] random_sign(logic [W-1:0] v);
        return $urandom_range(0, 1) ? -v : v;
    endfunction

    function automatic logic [W-1:0] pick_extreme();
        case ($urandom_range(0, 5))
            0: return '0;
            1: return 1;
            2: return '1;
            3: return MAX_POS;
            4: return MAX_NEG;
            default: return MOST_NEG;
        endcase
    endfunction

    task automatic send_random_fraction();
        logic [W-1:0] num, den, g;
        num = '0;
        den = '0;
        case ($urandom_range(0, 9))
            0, 1, 2: begin
                num = $urandom();
                den = $urandom();
            end
            3, 4: begin
                g   = $urandom_range(1, 65535);
                num = random_sign(g * $urandom_range(0, 32767));
                den = random_sign(g * $urandom_range(1, 32767));
            end
            5: begin
                num = random_sign($urandom_range(0, 20));
                den = random_sign($urandom_range(0, 20));
            end
            6: begin
                num = $urandom();
                den = '0;
            end
            7: begin
                num = '0;
                den = $urandom();
            end
            8: begin
                den = random_sign($urandom_range(1, 1000));
                num = random_sign(den * $urandom_range(0, 1000));
            end
            default: begin
                num = pick_extreme();
                den = $urandom_range(0, 1) ? pick_extreme() : $urandom();
            end
        endcase
        send_fraction(num, den);
    endtask

    initial begin
        wait (i_rst_n === 1'b1);
        @(negedge i_clk);
        forever take_result();
    end

    initial begin
        i_rst_n    = 1'b0;
        i_valid    = 1'b0;
        i_ready    = 1'b0;
        i_numer_in = '0;
        i_denom_in = '0;
        repeat (7) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        send_fraction(0, 0);
        send_fraction(5, 0);
        send_fraction(0, 7);
        send_fraction(0, -7);
        send_fraction(6, 8);
        send_fraction(-6, 8);
        send_fraction(6, -8);
        send_fraction(-6, -8);
        send_fraction(7, 3);
        send_fraction(-7, 3);
        send_fraction(7, -3);
        send_fraction(12, 4);
        send_fraction(3, 12);
        send_fraction(MAX_POS, 1);
        send_fraction(MAX_NEG, 1);
        send_fraction(MAX_POS, MAX_POS);
        send_fraction(MAX_POS, MAX_NEG);
        send_fraction(MOST_NEG, 1);
        send_fraction(1, MOST_NEG);
        send_fraction(MOST_NEG, MOST_NEG);
        send_fraction(1, MAX_POS);
        send_fraction(MAX_POS - 1, 2);
        send_fraction(MAX_POS - 1, -4);

        repeat (RANDOM_ITEMS) begin
            if ($urandom_range(0, 49) == 0) steady_in = !steady_in;
            send_random_fraction();
        end
        i_valid <= 1'b0;

        while (board.pending_fractions.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (board.mismatch_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
